// ===== rtl/lpfd_pkg.sv =====
// Shared beat types and protocol constants for the length-prefixed frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package lpfd_pkg;

  // Width of the register that assembles an extended length.
  localparam int unsigned ACC_W = 32;

  // Length byte escapes.
  localparam logic [7:0] LEN_EXT16 = 8'd254;
  localparam logic [7:0] LEN_EXT32 = 8'd255;

  // Opcodes, low nibble only.
  localparam logic [3:0] OP_DATA  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Frame kinds.
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_PONG    = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       first;
    logic       last;
  } out_beat_t;

endpackage
`default_nettype wire

// ===== rtl/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer.
//
//   channel | signals                       | direction | beat contents
//   --------+-------------------------------+-----------+---------------------------------
//   in      | in_valid, in_ready, in_beat   | input     | one stream byte, flush flag
//   out     | out_valid, out_ready, out_beat| output    | kind, byte, byte_valid, first, last
//
// One byte beat per cycle sustained unless a result waits for the output slot; a beat
// accepted is held in the input register, parsed there, and its result is loaded into
// the result register that drives out_valid (input register, then result register).
// The rate is set by the single parse stage between the two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// awaiting a length byte with the frame kind set to discard.
// A stalled out_ready holds the result register; the input register still drains
// beats that produce no result, and only a beat with a result waits for the slot.
`timescale 1ns / 1ps
`default_nettype none
module length_prefixed_frame_deframer #(
  parameter int unsigned LEN_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lpfd_pkg::in_beat_t  in_beat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lpfd_pkg::out_beat_t      out_beat
);

  logic                beat_valid;
  lpfd_pkg::in_beat_t  beat;
  logic                res_valid;
  lpfd_pkg::out_beat_t res;
  logic                out_free;
  logic                adv;

  // Advance the held beat when it yields no result or the result slot is open.
  assign adv = beat_valid && (!res_valid || out_free);

  lpfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .adv        (adv),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  // Parse state updates only when the held beat advances.
  lpfd_core #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

// ===== rtl/lpfd_in_reg.sv =====
// Input register stage holding one accepted byte beat.
`timescale 1ns / 1ps
`default_nettype none
module lpfd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lpfd_pkg::in_beat_t in_beat,
  input  wire logic              adv,
  output logic                   beat_valid,
  output lpfd_pkg::in_beat_t     beat
);

  logic               valid_r;
  logic               valid_nxt;
  lpfd_pkg::in_beat_t beat_r;
  logic               take;

  assign in_ready   = !valid_r || adv;
  assign take       = in_valid && in_ready;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_beat;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lpfd_core.sv =====
// Frame parse state and per-byte decode of the deframer.
`timescale 1ns / 1ps
`default_nettype none
module lpfd_core #(
  parameter int unsigned LEN_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire lpfd_pkg::in_beat_t beat,
  output logic                    res_valid,
  output lpfd_pkg::out_beat_t     res
);

  localparam logic [2:0] PH_LEN     = 3'd0;
  localparam logic [2:0] PH_EXT16   = 3'd1;
  localparam logic [2:0] PH_EXT32   = 3'd2;
  localparam logic [2:0] PH_OPCODE  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [lpfd_pkg::ACC_W-1:0] MaxLen =
    lpfd_pkg::ACC_W'((64'd1 << LEN_WIDTH) - 64'd1);

  logic [2:0]                   phase_r, phase_nxt;
  logic [lpfd_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [LEN_WIDTH-1:0]         left_r, left_nxt;
  logic [1:0]                   ext_r, ext_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic                         firstp_r, firstp_nxt;

  logic [lpfd_pkg::ACC_W-1:0]   acc_shift;
  logic [lpfd_pkg::ACC_W-1:0]   acc_clamp;
  logic [1:0]                   ext_inc;
  logic [1:0]                   ext_need;
  logic [LEN_WIDTH-1:0]         left_dec;
  logic [1:0]                   op_kind;
  logic [3:0]                   op;

  assign acc_shift = {acc_r[lpfd_pkg::ACC_W-9:0], beat.data_byte};
  assign acc_clamp = (acc_shift > MaxLen) ? MaxLen : acc_shift;
  assign ext_inc   = ext_r + 2'd1;
  // Four bytes wrap the two-bit count back to zero.
  assign ext_need  = (phase_r == PH_EXT16) ? 2'd2 : 2'd0;
  assign left_dec  = left_r - LEN_WIDTH'(1);
  assign op        = beat.data_byte[3:0];

  always_comb begin
    case (op)
      lpfd_pkg::OP_DATA:  op_kind = lpfd_pkg::KIND_DATA;
      lpfd_pkg::OP_CLOSE: op_kind = lpfd_pkg::KIND_CLOSE;
      lpfd_pkg::OP_PONG:  op_kind = lpfd_pkg::KIND_PONG;
      default:            op_kind = lpfd_pkg::KIND_DISCARD;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    left_nxt   = left_r;
    ext_nxt    = ext_r;
    kind_nxt   = kind_r;
    firstp_nxt = firstp_r;
    res_valid  = 1'b0;
    res        = '0;
    res.frame_kind = kind_r;

    if (beat.flush) begin
      phase_nxt  = PH_LEN;
      acc_nxt    = '0;
      left_nxt   = '0;
      ext_nxt    = '0;
      kind_nxt   = lpfd_pkg::KIND_DISCARD;
      firstp_nxt = 1'b1;
    end else begin
      case (phase_r)
        PH_LEN: begin
          if (beat.data_byte == lpfd_pkg::LEN_EXT16) begin
            phase_nxt = PH_EXT16;
            acc_nxt   = '0;
            ext_nxt   = '0;
          end else if (beat.data_byte == lpfd_pkg::LEN_EXT32) begin
            phase_nxt = PH_EXT32;
            acc_nxt   = '0;
            ext_nxt   = '0;
          end else begin
            left_nxt  = LEN_WIDTH'(beat.data_byte);
            phase_nxt = PH_OPCODE;
          end
        end
        PH_EXT16, PH_EXT32: begin
          acc_nxt = acc_shift;
          ext_nxt = ext_inc;
          if (ext_inc == ext_need) begin
            left_nxt  = LEN_WIDTH'(acc_clamp);
            ext_nxt   = '0;
            phase_nxt = PH_OPCODE;
          end
        end
        PH_OPCODE: begin
          kind_nxt   = op_kind;
          firstp_nxt = 1'b1;
          if (left_r == '0) begin
            phase_nxt = PH_LEN;
            // Empty frame of a kept kind: one marker with no data byte.
            if (op_kind != lpfd_pkg::KIND_DISCARD) begin
              res_valid      = 1'b1;
              res.frame_kind = op_kind;
              res.first      = 1'b1;
              res.last       = 1'b1;
            end
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          left_nxt   = left_dec;
          firstp_nxt = 1'b0;
          if (left_dec == '0) begin
            phase_nxt = PH_LEN;
          end
          if (kind_r != lpfd_pkg::KIND_DISCARD) begin
            res_valid        = 1'b1;
            res.payload_byte = beat.data_byte;
            res.byte_valid   = 1'b1;
            res.first        = firstp_r;
            res.last         = (left_dec == '0);
          end
        end
        default: begin
          phase_nxt  = PH_LEN;
          acc_nxt    = '0;
          left_nxt   = '0;
          ext_nxt    = '0;
          kind_nxt   = lpfd_pkg::KIND_DISCARD;
          firstp_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      acc_r    <= '0;
      left_r   <= '0;
      ext_r    <= '0;
      kind_r   <= lpfd_pkg::KIND_DISCARD;
      firstp_r <= 1'b1;
    end else if (step) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      left_r   <= left_nxt;
      ext_r    <= ext_nxt;
      kind_r   <= kind_nxt;
      firstp_r <= firstp_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lpfd_out_reg.sv =====
// Result register stage driving the output channel.
`timescale 1ns / 1ps
`default_nettype none
module lpfd_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire lpfd_pkg::out_beat_t res,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lpfd_pkg::out_beat_t      out_beat
);

  logic                valid_r;
  logic                valid_nxt;
  lpfd_pkg::out_beat_t beat_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the length-prefixed frame deframer.
`timescale 1ns / 1ps
module tb_top;
  import lpfd_pkg::*;

  localparam int unsigned LEN_W = 32;
  localparam logic [31:0] LEN_MAX = 32'((64'd1 << LEN_W) - 64'd1);
  localparam logic [3:0]  OP_PING = 4'h9;

  // Parser phases of the local deframing model.
  typedef enum logic [2:0] {
    AWAIT_LEN,
    AWAIT_EXT16,
    AWAIT_EXT32,
    AWAIT_OPCODE,
    IN_PAYLOAD
  } parse_phase_e;

  // One row of the directed table. When typed is set, has_out and the result fields
  // give the expectation by hand; otherwise the deframing model supplies it.
  typedef struct packed {
    logic [7:0] data;
    logic       flush;
    logic       typed;
    logic       has_out;
    logic [1:0] kind;
    logic [7:0] pbyte;
    logic       bvalid;
    logic       first;
    logic       last;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [24] = '{
    // empty data frame: one marker beat with no valid byte
    '{data: 8'h00, default: '0},
    '{data: 8'hF1, typed: 1'b1, has_out: 1'b1, kind: KIND_DATA, first: 1'b1, last: 1'b1,
      default: '0},
    // empty ping frame: consumed silently
    '{data: 8'h00, default: '0},
    '{data: 8'hF9, typed: 1'b1, default: '0},
    // two-byte closing frame with extreme payload bytes
    '{data: 8'h02, default: '0},
    '{data: 8'h88, default: '0},
    '{data: 8'h00, typed: 1'b1, has_out: 1'b1, kind: KIND_CLOSE, pbyte: 8'h00, bvalid: 1'b1,
      first: 1'b1, default: '0},
    '{data: 8'hFF, typed: 1'b1, has_out: 1'b1, kind: KIND_CLOSE, pbyte: 8'hFF, bvalid: 1'b1,
      last: 1'b1, default: '0},
    // 16-bit extended length of one, pong frame
    '{data: LEN_EXT16, default: '0},
    '{data: 8'h00, default: '0},
    '{data: 8'h01, default: '0},
    '{data: 8'h0A, default: '0},
    '{data: 8'hA5, typed: 1'b1, has_out: 1'b1, kind: KIND_PONG, pbyte: 8'hA5, bvalid: 1'b1,
      first: 1'b1, last: 1'b1, default: '0},
    // 32-bit extended length of three, data frame cut short by a flush
    '{data: LEN_EXT32, default: '0},
    '{data: 8'h00, default: '0},
    '{data: 8'h00, default: '0},
    '{data: 8'h00, default: '0},
    '{data: 8'h03, default: '0},
    '{data: 8'h01, default: '0},
    '{data: 8'h5A, typed: 1'b1, has_out: 1'b1, kind: KIND_DATA, pbyte: 8'h5A, bvalid: 1'b1,
      first: 1'b1, default: '0},
    '{data: 8'hFF, flush: 1'b1, typed: 1'b1, default: '0},
    // fresh frame after the flush with an opcode that is dropped
    '{data: 8'h01, default: '0},
    '{data: 8'h02, default: '0},
    '{data: 8'h7E, typed: 1'b1, default: '0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  length_prefixed_frame_deframer #(.LEN_WIDTH(LEN_W)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Deframing model state.
  parse_phase_e parse_ph;
  logic [31:0]  len_left;
  logic [2:0]   ext_seen;
  logic [1:0]   cur_kind;
  logic         first_due;

  out_beat_t    pending_frames_q [$];   // results still owed by the block
  in_beat_t     stream_q [$];           // random byte stream, built up front

  int unsigned  mismatches;
  int unsigned  beats_sent;
  int unsigned  flushes_sent;
  int unsigned  stream_bytes;
  int unsigned  results_seen;
  int unsigned  markers_seen;
  int unsigned  ext16_frames;
  int unsigned  ext32_frames;
  int unsigned  input_stall_cycles;
  int unsigned  burst_left;

  bit           hold_request;
  bit           hold_done;
  int unsigned  hold_left;
  int unsigned  rx_mode;
  int unsigned  rx_mode_left;
  logic [15:0]  rx_pattern = 16'b1011_0111_0010_1101;

  out_beat_t    want;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] MISMATCH at result %0d: %s", $time, results_seen, what);
  endtask

  // Return the parser to awaiting a length byte.
  function automatic void parser_clear();
    parse_ph  = AWAIT_LEN;
    len_left  = '0;
    ext_seen  = '0;
    cur_kind  = KIND_DISCARD;
    first_due = 1'b1;
  endfunction

  // Advance the deframing model by one byte beat; return 1 when it yields a result.
  function automatic bit deframe_byte(input in_beat_t b, output out_beat_t r);
    logic [3:0] op;
    bit         tail;
    bit         head;
    r = '0;
    if (b.flush) begin
      parser_clear();
      return 1'b0;
    end
    case (parse_ph)
      AWAIT_LEN: begin
        if (b.data_byte == LEN_EXT16) begin
          parse_ph = AWAIT_EXT16;
          len_left = '0;
          ext_seen = '0;
          ext16_frames++;
        end else if (b.data_byte == LEN_EXT32) begin
          parse_ph = AWAIT_EXT32;
          len_left = '0;
          ext_seen = '0;
          ext32_frames++;
        end else begin
          len_left = {24'd0, b.data_byte};
          parse_ph = AWAIT_OPCODE;
        end
        return 1'b0;
      end
      AWAIT_EXT16, AWAIT_EXT32: begin
        // shift in big-endian; take the length only once every byte is in
        len_left = {len_left[23:0], b.data_byte};
        ext_seen++;
        if (ext_seen == ((parse_ph == AWAIT_EXT16) ? 3'd2 : 3'd4)) begin
          if (LEN_W < 32 && len_left > LEN_MAX) len_left = LEN_MAX;
          ext_seen = '0;
          parse_ph = AWAIT_OPCODE;
        end
        return 1'b0;
      end
      AWAIT_OPCODE: begin
        op = b.data_byte[3:0];
        case (op)
          OP_DATA:  cur_kind = KIND_DATA;
          OP_CLOSE: cur_kind = KIND_CLOSE;
          OP_PONG:  cur_kind = KIND_PONG;
          default:  cur_kind = KIND_DISCARD;
        endcase
        first_due = 1'b1;
        if (len_left == '0) begin
          parse_ph = AWAIT_LEN;
          if (cur_kind == KIND_DISCARD) return 1'b0;
          r = '{frame_kind: cur_kind, payload_byte: 8'h00, byte_valid: 1'b0,
                first: 1'b1, last: 1'b1};
          return 1'b1;
        end
        parse_ph = IN_PAYLOAD;
        return 1'b0;
      end
      IN_PAYLOAD: begin
        head      = first_due;
        len_left  = len_left - 32'd1;
        tail      = (len_left == '0);
        first_due = 1'b0;
        if (tail) parse_ph = AWAIT_LEN;
        if (cur_kind == KIND_DISCARD) return 1'b0;
        r = '{frame_kind: cur_kind, payload_byte: b.data_byte, byte_valid: 1'b1,
              first: head, last: tail};
        return 1'b1;
      end
      default: begin
        parser_clear();
        return 1'b0;
      end
    endcase
  endfunction

  // Offer one beat, hold it until accepted, then log what the block owes for it.
  // Bursts of random length are separated by random gaps.
  task automatic send_beat(input in_beat_t b, input bit typed, input bit typed_has,
                           input out_beat_t typed_out);
    out_beat_t predicted;
    bit        yields;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_beat  <= b;
    do begin
      @(posedge clk);
      if (in_ready !== 1'b1) input_stall_cycles++;
    end while (in_ready !== 1'b1);
    beats_sent++;
    if (b.flush) flushes_sent++;
    yields = deframe_byte(b, predicted);
    // hand-typed rows override the model's verdict but keep its state moving
    if (typed) begin
      yields    = typed_has;
      predicted = typed_out;
    end
    if (yields) pending_frames_q.push_back(predicted);
  endtask

  // Drop valid and hold off until every owed result has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_frames_q.size() != 0);
  endtask

  task automatic push_byte(input logic [7:0] b);
    stream_q.push_back('{data_byte: b, flush: 1'b0});
    stream_bytes++;
  endtask

  task automatic push_flush();
    stream_q.push_back('{data_byte: 8'($urandom), flush: 1'b1});
  endtask

  // Append one frame: mostly well formed with random content, some cut short by a flush,
  // some announcing lengths far too long to finish.
  task automatic compose_frame();
    int unsigned sel;
    int unsigned plen;
    int unsigned keep;
    logic [31:0] wide;
    logic [7:0]  opc;
    bit          broken;
    sel    = $urandom_range(0, 99);
    broken = ($urandom_range(0, 14) == 0);
    if (sel < 65) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 253) : $urandom_range(0, 12);
      push_byte(plen[7:0]);
    end else if (sel < 80) begin
      plen = $urandom_range(0, 300);
      push_byte(LEN_EXT16);
      push_byte(plen[15:8]);
      push_byte(plen[7:0]);
    end else if (sel < 92) begin
      plen = $urandom_range(0, 20);
      push_byte(LEN_EXT32);
      for (int k = 3; k >= 0; k--) push_byte(plen[k*8 +: 8]);
    end else begin
      // huge length: random extended bytes, always cut short
      wide   = $urandom;
      broken = 1'b1;
      if (sel < 96) begin
        push_byte(LEN_EXT16);
        push_byte(wide[15:8]);
        push_byte(wide[7:0]);
        plen = {16'd0, wide[15:0]};
      end else begin
        push_byte(LEN_EXT32);
        for (int k = 3; k >= 0; k--) push_byte(wide[k*8 +: 8]);
        plen = wide;
      end
    end
    if (broken && $urandom_range(0, 3) == 0) begin
      push_flush();
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: opc[3:0] = OP_DATA;
      3, 4:    opc[3:0] = OP_CLOSE;
      5, 6:    opc[3:0] = OP_PONG;
      7:       opc[3:0] = OP_PING;
      default: opc[3:0] = 4'($urandom);
    endcase
    opc[7:4] = 4'($urandom);
    push_byte(opc);
    keep = broken ? $urandom_range(0, (plen < 8) ? plen : 8) : plen;
    for (int unsigned k = 0; k < keep; k++) push_byte(8'($urandom));
    if (broken) push_flush();
  endtask

  // Receiver: one long hold-off when asked, otherwise a changing stall pattern.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 80);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: begin
          out_ready  <= rx_pattern[0];
          rx_pattern  = {rx_pattern[0], rx_pattern[15:1]};
        end
        2:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare every accepted result against the oldest owed one, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (out_beat.byte_valid === 1'b0) markers_seen++;
      if (pending_frames_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_beat));
      end else begin
        want = pending_frames_q.pop_front();
        if (out_beat.frame_kind !== want.frame_kind)
          report_mismatch($sformatf("frame_kind %0d, want %0d",
                                    out_beat.frame_kind, want.frame_kind));
        if (out_beat.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %02h, want %02h",
                                    out_beat.payload_byte, want.payload_byte));
        if (out_beat.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b",
                                    out_beat.byte_valid, want.byte_valid));
        if (out_beat.first !== want.first)
          report_mismatch($sformatf("first %b, want %b", out_beat.first, want.first));
        if (out_beat.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_beat.last, want.last));
      end
    end
  end

  initial begin : main_flow
    directed_row_t row;
    parser_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: empty frames, every opcode class, both extended lengths, flush.
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      send_beat('{data_byte: row.data, flush: row.flush}, row.typed, row.has_out,
                '{frame_kind: row.kind, payload_byte: row.pbyte, byte_valid: row.bvalid,
                  first: row.first, last: row.last});
    end
    wait_for_drain();

    // Random frames until enough stream bytes are queued; flushes do not count.
    while (stream_bytes < 700) begin
      if ($urandom_range(0, 19) == 0) push_flush();
      compose_frame();
    end

    // Start the long receiver hold-off while the sender keeps offering beats.
    hold_request = 1'b1;
    foreach (stream_q[i]) begin
      if (i == stream_q.size() / 2) wait_for_drain();
      send_beat(stream_q[i], 1'b0, 1'b0, '0);
    end
    wait_for_drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d input beats (%0d flushes) and %0d results,",
             beats_sent, flushes_sent, results_seen);
    $display("%0d empty-frame markers, %0d 16-bit and %0d 32-bit lengths, %0d stall cycles.",
             markers_seen, ext16_frames, ext32_frames, input_stall_cycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake or results that never arrive.
  initial begin
    #(3_000_000);
    $display("Timeout with %0d results still owed.", pending_frames_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== length_prefixed_frame_deframer.f =====
rtl/lpfd_pkg.sv
rtl/lpfd_in_reg.sv
rtl/lpfd_core.sv
rtl/lpfd_out_reg.sv
rtl/length_prefixed_frame_deframer.sv
dv/tb_top.sv
